>>> rtl/core/bcdrtc_pkg.sv
// Package: word types, status codes and calendar tables for the BCD RTC to epoch converter
`timescale 1ns / 1ps

package bcdrtc_pkg;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OSC_STOP = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result queue in the back end
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  // Days from 1970-01-01 to 2000-01-01
  localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;

  typedef struct packed {
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [7:0] day_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [1:0]  status;
  } out_word_t;

  // Classified snapshot handed from front to back end
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cls_word_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Decode a BCD byte as high nibble times ten plus low nibble
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    bcd_decode = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
  endfunction

  // Days in month for a valid month code
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:    days_in_month = leap ? 5'd29 : 5'd28;
      4'd4:    days_in_month = 5'd30;
      4'd6:    days_in_month = 5'd30;
      4'd9:    days_in_month = 5'd30;
      4'd11:   days_in_month = 5'd30;
      default: days_in_month = 5'd31;
    endcase
  endfunction

  // Days in the year before the first of the month, common year
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    case (m)
      4'd1:    days_before_month = 9'd0;
      4'd2:    days_before_month = 9'd31;
      4'd3:    days_before_month = 9'd59;
      4'd4:    days_before_month = 9'd90;
      4'd5:    days_before_month = 9'd120;
      4'd6:    days_before_month = 9'd151;
      4'd7:    days_before_month = 9'd181;
      4'd8:    days_before_month = 9'd212;
      4'd9:    days_before_month = 9'd243;
      4'd10:   days_before_month = 9'd273;
      4'd11:   days_before_month = 9'd304;
      4'd12:   days_before_month = 9'd334;
      default: days_before_month = 9'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/bcd_rtc_time_to_epoch.sv
// Top level: BCD RTC calendar snapshot to UTC seconds since 1970
//
// Input channel: in_word carries six BCD calendar bytes; a word is taken at a
// clock edge with in_push high and in_full low. Bit 7 of the seconds byte is
// the oscillator-stop flag.
// Result channel: out_word holds epoch_seconds and status of the oldest
// finished word while out_empty is low; it is taken with out_pop high.
// Status 0 is ok, 1 oscillator stopped, 2 calendar out of range; epoch is 0
// unless status is 0. One result for every input word, in order.
// An accepted word passes the input stage, hand-off queue, day-count stage
// and epoch multiply stage, then lands in the result queue.
// Throughput: one word per cycle while out_pop stays high; the 4-entry result
// queue covers both compute stages, so issue goes on while results drain.
// Stalls: when out_pop stays low the result queue fills, the back end stops
// drawing from the 4-entry hand-off queue and in_full rises once that and the
// input stage are full. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties every queue and stage; the block
// keeps no other state and accepts words the cycle after reset ends.
`timescale 1ns / 1ps

module bcd_rtc_time_to_epoch import bcdrtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  q_stat_t   q_stat;
  logic      q_push, q_pop;
  cls_word_t q_wdata, q_rdata;

  // Decode and classify
  bcdrtc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // Hand-off queue
  bcdrtc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Epoch arithmetic and result queue
  bcdrtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/bcdrtc_front.sv
// Front end: decode the BCD snapshot, check ranges and register the classified word
`timescale 1ns / 1ps

module bcdrtc_front import bcdrtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  q_stat_t   q_stat,
  output logic      q_push,
  output cls_word_t q_wdata
);

  logic       stg_v_r, stg_v_nxt;
  cls_word_t  stg_r;
  cls_word_t  cls;
  logic [7:0] sec_d, min_d, hr_d, day_d, mon_d, yr_d;
  logic       leap, bad_range, bad_day;
  logic       load;

  // Decode every byte; the seconds byte loses its stop flag
  always_comb begin
    sec_d = bcd_decode({1'b0, in_word.seconds_byte[6:0]});
    min_d = bcd_decode(in_word.minutes_byte);
    hr_d  = bcd_decode(in_word.hours_byte);
    day_d = bcd_decode(in_word.day_byte);
    mon_d = bcd_decode(in_word.month_byte);
    yr_d  = bcd_decode(in_word.year_byte);
  end

  // Classify: stop flag first, then the calendar ranges
  always_comb begin
    // 2000 is a leap year, so every fourth year of the century is one
    leap      = (yr_d[1:0] == 2'd0);
    bad_range = (yr_d > 8'd99) || (mon_d < 8'd1) || (mon_d > 8'd12) ||
                (hr_d > 8'd23) || (min_d > 8'd59) || (sec_d > 8'd59);
    bad_day   = (day_d < 8'd1) ||
                (day_d > {3'd0, days_in_month(mon_d[3:0], leap)});
    cls.year   = yr_d[6:0];
    cls.month  = mon_d[3:0];
    cls.day    = day_d[4:0];
    cls.hour   = hr_d[4:0];
    cls.minute = min_d[5:0];
    cls.second = sec_d[5:0];
    if (in_word.seconds_byte[7]) begin
      cls.status = STATUS_OSC_STOP;
    end else if (bad_range || bad_day) begin
      cls.status = STATUS_RANGE;
    end else begin
      cls.status = STATUS_OK;
    end
  end

  // Hand the staged word on whenever the queue has room
  assign q_push  = stg_v_r && !q_stat.full;
  assign q_wdata = stg_r;
  assign in_full = stg_v_r && q_stat.full;
  assign load    = in_push && !in_full;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (load) begin
      stg_v_nxt = 1'b1;
    end else if (q_push) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Payload stage
  always_ff @(posedge clk) begin
    if (load) begin
      stg_r <= cls;
    end
  end

endmodule

>>> rtl/core/bcdrtc_queue.sv
// Short queue of classified words between front and back end
`timescale 1ns / 1ps

module bcdrtc_queue import bcdrtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t wdata,
  input  logic      pop,
  output cls_word_t rdata,
  output q_stat_t   stat
);

  cls_word_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/bcdrtc_back.sv
// Back end: day count, time of day, epoch multiply and result queue
`timescale 1ns / 1ps

module bcdrtc_back import bcdrtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cls_word_t q_rdata,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  // Stage 1: day count and seconds into the day
  logic        s1_v_r;
  logic [1:0]  s1_status_r;
  logic [15:0] s1_days_r, days;
  logic [16:0] s1_tod_r, tod;
  // Stage 2: finished word
  logic        s2_v_r;
  out_word_t   s2_word_r;
  logic [31:0] epoch;
  // Result queue
  out_word_t         omem [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_ptr_r, ord_ptr_r;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [OCNT_W:0]   occ;
  logic              o_rd;
  logic              leap_adj;

  // Issue only when every word in flight has a place in the result queue
  assign occ   = {1'b0, ocnt_r} + (OCNT_W+1)'(s1_v_r) + (OCNT_W+1)'(s2_v_r);
  assign q_pop = !q_stat.empty && (occ < (OCNT_W+1)'(OUT_DEPTH));

  // Days since 1970: whole years from 2000, leap days, then the day of year
  always_comb begin
    leap_adj = (q_rdata.year[1:0] == 2'd0) && (q_rdata.month > 4'd2);
    days = DAYS_TO_2000
         + 16'(q_rdata.year) * 16'd365
         + ((16'(q_rdata.year) + 16'd3) >> 2)
         + 16'(days_before_month(q_rdata.month))
         + 16'(leap_adj)
         + 16'(q_rdata.day) - 16'd1;
    tod  = 17'(q_rdata.hour) * 17'd3600 + 17'(q_rdata.minute) * 17'd60
         + 17'(q_rdata.second);
  end

  assign epoch = 32'(s1_days_r) * SECS_PER_DAY + 32'(s1_tod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_status_r <= q_rdata.status;
      s1_days_r   <= days;
      s1_tod_r    <= tod;
    end
    if (s1_v_r) begin
      s2_word_r.status        <= s1_status_r;
      s2_word_r.epoch_seconds <= (s1_status_r == STATUS_OK) ? epoch : 32'd0;
    end
  end

  // Result queue: room is reserved at issue, so a write always fits
  assign out_empty = (ocnt_r == '0);
  assign o_rd      = out_pop && !out_empty;
  assign out_word  = omem[ord_ptr_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (s2_v_r && !o_rd) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (o_rd && !s2_v_r) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      if (s2_v_r) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (o_rd) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      omem[owr_ptr_r] <= s2_word_r;
    end
  end

endmodule

>>> rtl/core/bcdrtc_checker.sv
// Port checker for the BCD RTC to epoch converter, bound to the top level
`timescale 1ns / 1ps

module bcdrtc_checker import bcdrtc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_word_t out_word
);

  // Reset leaves no result waiting and the input open
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A failed conversion always reports epoch zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status != STATUS_OK) |-> out_word.epoch_seconds == 32'd0)
    else $error("non-zero epoch with error status");

  // Status code 3 never leaves the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.status == STATUS_OK || out_word.status == STATUS_OSC_STOP ||
                    out_word.status == STATUS_RANGE))
    else $error("unused status code");

  // A good epoch lies inside the years 2000 to 2099
  a_epoch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status == STATUS_OK) |->
      (out_word.epoch_seconds >= 32'd946684800 && out_word.epoch_seconds <= 32'd4102444799))
    else $error("epoch out of range");

  // Hold a waiting result word steady until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result word changed");

endmodule

bind bcd_rtc_time_to_epoch bcdrtc_checker u_chk (.*);

>>> bench/tb.sv
// Testbench: BCD RTC calendar snapshot to epoch converter, with a self-checking scoreboard
`timescale 1ns / 1ps

package rtc_epoch_check_pkg;
  import bcdrtc_pkg::*;

  // Read a register byte as high nibble times ten plus low nibble, any nibble allowed
  function automatic int unsigned nibble_pair(input logic [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  // Gregorian month length
  function automatic int unsigned month_span(input int unsigned mon, input int unsigned yr);
    bit leap_year;
    leap_year = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mon)
      2: begin
        return leap_year ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Work out the result word for one calendar snapshot
  function automatic out_word_t rtc_to_epoch(input in_word_t w);
    int unsigned     sec, minute, hour, day, mon, yr;
    int unsigned     shifted_yr, era, year_of_era, mar_month, day_of_year, day_of_era;
    longint unsigned day_count, total;
    out_word_t       r;
    r.epoch_seconds = '0;
    r.status        = STATUS_OK;
    // oscillator stop wins over everything else
    if (w.seconds_byte[7]) begin
      r.status = STATUS_OSC_STOP;
      return r;
    end
    sec    = nibble_pair({1'b0, w.seconds_byte[6:0]});
    minute = nibble_pair(w.minutes_byte);
    hour   = nibble_pair(w.hours_byte);
    day    = nibble_pair(w.day_byte);
    mon    = nibble_pair(w.month_byte);
    yr     = nibble_pair(w.year_byte) + 2000;
    if (yr > 2099 || mon < 1 || mon > 12 || hour > 23 || minute > 59 || sec > 59) begin
      r.status = STATUS_RANGE;
      return r;
    end
    if (day < 1 || day > month_span(mon, yr)) begin
      r.status = STATUS_RANGE;
      return r;
    end
    // days from civil: year taken to start in March
    shifted_yr  = (mon <= 2) ? yr - 1 : yr;
    era         = shifted_yr / 400;
    year_of_era = shifted_yr - era * 400;
    mar_month   = (mon > 2) ? mon - 3 : mon + 9;
    day_of_year = (153 * mar_month + 2) / 5 + day - 1;
    day_of_era  = year_of_era * 365 + year_of_era / 4 - year_of_era / 100 + day_of_year;
    day_count   = longint'(era) * 146097 + longint'(day_of_era) - 719468;
    total       = day_count * 86400 + longint'(hour) * 3600 + longint'(minute) * 60 + sec;
    r.epoch_seconds = total[31:0];
    return r;
  endfunction

  // In-order store of expected result words
  class epoch_scoreboard;
    out_word_t   epoch_due_q[$];
    int unsigned words_noted;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned unexpected;
    int unsigned ok_count;
    int unsigned osc_count;
    int unsigned range_count;

    function void note_snapshot(input in_word_t w);
      out_word_t due;
      due = rtc_to_epoch(w);
      case (due.status)
        STATUS_OK: begin
          ok_count++;
        end
        STATUS_OSC_STOP: begin
          osc_count++;
        end
        default: begin
          range_count++;
        end
      endcase
      epoch_due_q.push_back(due);
      words_noted++;
    endfunction

    function void check_result(input out_word_t got);
      out_word_t due;
      if (epoch_due_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: result word with nothing due: epoch %0d status %0d",
                   got.epoch_seconds, got.status);
        return;
      end
      due = epoch_due_q.pop_front();
      words_checked++;
      if (got.epoch_seconds !== due.epoch_seconds || got.status !== due.status) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: word %0d: expected epoch %0d status %0d, got epoch %0d status %0d",
                   words_checked - 1, due.epoch_seconds, due.status,
                   got.epoch_seconds, got.status);
      end
    endfunction

    function int unsigned pending();
      return epoch_due_q.size();
    endfunction
  endclass

endpackage

module tb;
  import bcdrtc_pkg::*;
  import rtc_epoch_check_pkg::*;

  localparam int RANDOM_WORDS   = 1400;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 8;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_word_t  in_word;
  logic      out_pop;
  logic      out_empty;
  out_word_t out_word;

  epoch_scoreboard sb;
  bit              steady;
  bit              hold_request;
  int unsigned     full_stalls;

  bcd_rtc_time_to_epoch u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Encode a value as two nibbles, sometimes with a low nibble above nine
  function automatic logic [7:0] encode_digits(input int unsigned v, input bit loose);
    int unsigned lo_h, hi_h, h, l;
    hi_h = (v / 10 > 15) ? 15 : v / 10;
    lo_h = (v > 15) ? (v - 15 + 9) / 10 : 0;
    h = hi_h;
    if (loose && lo_h < hi_h && $urandom_range(3) == 0)
      h = $urandom_range(hi_h, lo_h);
    l = v - 10 * h;
    return {h[3:0], l[3:0]};
  endfunction

  // Build one random snapshot: mostly valid calendars, some broken, some stopped, some noise
  function automatic in_word_t make_snapshot();
    in_word_t    w;
    logic [63:0] noise;
    int unsigned kind, yr, mon, day, hour, minute, sec, maxd;
    kind = $urandom_range(99);
    if (kind >= 88) begin
      noise = {$urandom(), $urandom()};
      w = noise[47:0];
      return w;
    end
    yr   = $urandom_range(99);
    mon  = $urandom_range(12, 1);
    maxd = month_span(mon, yr + 2000);
    day  = $urandom_range(1) ? maxd - $urandom_range(2) : $urandom_range(maxd, 1);
    hour   = $urandom_range(3) == 0 ? 23 : $urandom_range(23);
    minute = $urandom_range(3) == 0 ? 59 : $urandom_range(59);
    sec    = $urandom_range(3) == 0 ? 59 : $urandom_range(59);
    // push one field past its legal range
    if (kind >= 70 && kind < 80) begin
      case ($urandom_range(5))
        0: sec    = $urandom_range(79, 60);
        1: minute = $urandom_range(165, 60);
        2: hour   = $urandom_range(1) ? 24 : $urandom_range(165, 24);
        3: day    = $urandom_range(1) ? 0 : ($urandom_range(1) ? maxd + 1 : $urandom_range(165, maxd + 1));
        4: mon    = $urandom_range(1) ? 0 : $urandom_range(165, 13);
        default: yr = $urandom_range(165, 100);
      endcase
    end
    w.seconds_byte = encode_digits(sec, 1'b1);
    w.minutes_byte = encode_digits(minute, 1'b1);
    w.hours_byte   = encode_digits(hour, 1'b1);
    w.day_byte     = encode_digits(day, 1'b1);
    w.month_byte   = encode_digits(mon, 1'b1);
    w.year_byte    = encode_digits(yr, 1'b1);
    if (kind >= 80 && kind < 88)
      w.seconds_byte[7] = 1'b1;
    return w;
  endfunction

  // Offer one word, idling at random first, and hold it until taken
  task automatic send_word(input in_word_t w);
    while (!steady && $urandom_range(99) < 37) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    sb.note_snapshot(w);
  endtask

  // Result side: pop at random, or hold off for a long stretch on request
  initial begin : result_side
    bit pop_now;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        pop_now = steady || ($urandom_range(99) >= 37);
        out_pop <= pop_now;
        @(posedge clk);
        if (pop_now && !out_empty)
          sb.check_result(out_word);
      end
    end
  end

  initial begin : stimulus
    in_word_t    directed_q[$];
    int unsigned guard;
    int unsigned leftover;
    int unsigned failures;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_word      = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    full_stalls  = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seconds, minutes, hours, day, month, year
    directed_q = '{
      '{8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00},  // oscillator stopped, calendar fine
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},  // oscillator stopped, all ones
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // all zero: day and month zero
      '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00},  // first second of 2000
      '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99},  // last second of 2099
      '{8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h00},  // leap day in a century leap year
      '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h01},  // leap day in a common year
      '{8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h01},
      '{8'h07, 8'h06, 8'h05, 8'h29, 8'h02, 8'h24},
      '{8'h00, 8'h00, 8'h00, 8'h30, 8'h02, 8'h24},
      '{8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h10},  // 31st of a 30-day month
      '{8'h00, 8'h00, 8'h00, 8'h30, 8'h04, 8'h10},
      '{8'h00, 8'h00, 8'h00, 8'h15, 8'h00, 8'h10},  // month zero
      '{8'h00, 8'h00, 8'h00, 8'h15, 8'h13, 8'h10},  // month thirteen
      '{8'h00, 8'h00, 8'h24, 8'h15, 8'h06, 8'h10},  // hour past 23
      '{8'h00, 8'h60, 8'h23, 8'h15, 8'h06, 8'h10},  // minute past 59
      '{8'h60, 8'h59, 8'h23, 8'h15, 8'h06, 8'h10},  // second past 59
      '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0},  // year decodes to 2100
      '{8'h4F, 8'h1A, 8'h0F, 8'h0F, 8'h0A, 8'h1F},  // non-decimal nibbles, still legal
      '{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},  // flag clear, every field too large
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00},  // day zero
      '{8'h59, 8'h59, 8'h23, 8'h31, 8'h01, 8'h38},  // past the signed 32-bit rollover
      '{8'h00, 8'h00, 8'h00, 8'h1F, 8'h0C, 8'h99}
    };
    foreach (directed_q[i])
      send_word(directed_q[i]);

    // random words, with a stretch of no idling and a long result hold-off
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 400 && n < 700);
      if (n == 1000)
        hold_request = 1'b1;
      send_word(make_snapshot());
    end
    in_push <= 1'b0;
    steady = 1'b0;

    // drain, then keep watching for stray words
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    leftover = sb.pending();
    if (leftover != 0)
      $display("ERROR: %0d expected result words never arrived", leftover);
    failures = sb.mismatches + sb.unexpected + leftover;
    $display("Checked %0d of %0d snapshots: %0d valid, %0d oscillator stopped, %0d out of range",
             sb.words_checked, sb.words_noted, sb.ok_count, sb.osc_count, sb.range_count);
    $display("Input held off for %0d cycles; %0d mismatches, %0d unexpected words",
             full_stalls, sb.mismatches, sb.unexpected);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(4_000_000);
    $display("ERROR: run timed out");
    $display("Test completed with failures");
    $finish;
  end

endmodule
